// ===== rtl/gqhm_pkg.sv =====
// Shared types, widths and constants for the Gray-coded QAM Hermitian mapper.
// No dependencies; every other rtl file imports this package.
package gqhm_pkg;

   localparam int BITS_PER_SYMBOL_DEF = 4;
   localparam int FFT_SIZE_DEF        = 64;

   localparam int SYM_W      = 8;
   localparam int BIN_W      = 6;
   localparam int VAL_W      = 21;
   localparam int GAIN_W     = 16;
   localparam int LEVEL_W    = 5;
   localparam int GRAY_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;

   localparam logic [GAIN_W-1:0] DATA_GAIN_RST = 16'd8192;
   localparam logic [GAIN_W-1:0] SYNC_GAIN_RST = 16'd11585;

   typedef enum logic [0:0] {
      REG_DATA_GAIN = 1'b0,
      REG_SYNC_GAIN = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im_prod;
      logic                    sync;
      logic                    start;
   } value_type;

   function automatic logic [GRAY_W-1:0] gray_lookup(input logic [GRAY_W-1:0] idx);
      logic [GRAY_W-1:0] g;
      case (idx)
         4'd0:    g = 4'd0;
         4'd1:    g = 4'd1;
         4'd2:    g = 4'd3;
         4'd3:    g = 4'd2;
         4'd4:    g = 4'd6;
         4'd5:    g = 4'd7;
         4'd6:    g = 4'd5;
         4'd7:    g = 4'd4;
         4'd8:    g = 4'd12;
         4'd9:    g = 4'd13;
         4'd10:   g = 4'd15;
         4'd11:   g = 4'd14;
         4'd12:   g = 4'd10;
         4'd13:   g = 4'd11;
         4'd14:   g = 4'd9;
         default: g = 4'd8;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/gqhm_csr.sv =====
// Gain registers behind the APB-style configuration port.
// Depends on gqhm_pkg.
module gqhm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gqhm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gqhm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gqhm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [gqhm_pkg::GAIN_W-1:0]       data_gain,
   output logic [gqhm_pkg::GAIN_W-1:0]       sync_gain
);
   import gqhm_pkg::*;

   logic [GAIN_W-1:0] data_gain_ff, data_gain_in;
   logic [GAIN_W-1:0] sync_gain_ff, sync_gain_in;
   reg_index_type     reg_sel;
   logic              wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      data_gain_in = data_gain_ff;
      sync_gain_in = sync_gain_ff;
      csr_prdata   = '0;
      unique case (reg_sel)
         REG_DATA_GAIN: begin
            csr_prdata = CSR_DATA_W'(data_gain_ff);
            if (wr_en) data_gain_in = csr_pwdata[GAIN_W-1:0];
         end
         REG_SYNC_GAIN: begin
            csr_prdata = CSR_DATA_W'(sync_gain_ff);
            if (wr_en) sync_gain_in = csr_pwdata[GAIN_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_gain_ff <= DATA_GAIN_RST;
         sync_gain_ff <= SYNC_GAIN_RST;
      end else begin
         data_gain_ff <= data_gain_in;
         sync_gain_ff <= sync_gain_in;
      end
   end

   assign data_gain = data_gain_ff;
   assign sync_gain = sync_gain_ff;

endmodule

// ===== rtl/gqhm_level.sv =====
// Input register, Gray level mapping and gain multiply into the value register.
// Depends on gqhm_pkg.
module gqhm_level #(
   parameter int BITS_PER_SYMBOL = gqhm_pkg::BITS_PER_SYMBOL_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gqhm_pkg::SYM_W-1:0]        req_tdata,
   input  logic [gqhm_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic [gqhm_pkg::GAIN_W-1:0]       data_gain,
   input  logic [gqhm_pkg::GAIN_W-1:0]       sync_gain,
   output logic                              val_valid,
   output gqhm_pkg::value_type               val_item,
   input  logic                              val_done
);
   import gqhm_pkg::*;

   localparam int HALF_BITS = BITS_PER_SYMBOL / 2;
   localparam int I_SHIFT   = BITS_PER_SYMBOL - HALF_BITS;
   localparam logic [GRAY_W-1:0] HALF_MASK = GRAY_W'((1 << HALF_BITS) - 1);
   localparam logic signed [LEVEL_W:0] LEVEL_OFFSET = (LEVEL_W+1)'((1 << HALF_BITS) - 1);

   logic              a_valid_ff, a_valid_in;
   logic [SYM_W-1:0]  a_bits_ff;
   logic              a_sync_ff, a_start_ff;
   logic              b_valid_ff, b_valid_in;
   value_type         b_ff, b_in;
   logic              a_load, b_load;

   logic [SYM_W-1:0]           i_shift;
   logic [GRAY_W-1:0]          i_idx, q_idx;
   logic signed [LEVEL_W:0]    i_wide, q_wide;
   logic signed [LEVEL_W-1:0]  i_level, q_level;
   logic [GAIN_W-1:0]          gain;
   logic signed [LEVEL_W+GAIN_W:0] i_prod, q_prod;

   assign b_load     = a_valid_ff & (~b_valid_ff | val_done);
   assign req_tready = ~a_valid_ff | b_load;
   assign a_load     = req_tvalid & req_tready;
   assign a_valid_in = a_load | (a_valid_ff & ~b_load);
   assign b_valid_in = b_load | (b_valid_ff & ~val_done);

   always_comb begin
      i_shift = a_bits_ff >> I_SHIFT;
      i_idx   = i_shift[GRAY_W-1:0] & HALF_MASK;
      q_idx   = a_bits_ff[GRAY_W-1:0] & HALF_MASK;
      i_wide  = $signed({1'b0, gray_lookup(i_idx), 1'b0}) - LEVEL_OFFSET;
      q_wide  = $signed({1'b0, gray_lookup(q_idx), 1'b0}) - LEVEL_OFFSET;
      i_level = i_wide[LEVEL_W-1:0];
      q_level = q_wide[LEVEL_W-1:0];
      gain    = a_sync_ff ? sync_gain : data_gain;
      i_prod  = i_level * $signed({1'b0, gain});
      q_prod  = q_level * $signed({1'b0, gain});
      b_in.re      = i_prod[VAL_W-1:0];
      b_in.im_prod = q_prod[VAL_W-1:0];
      b_in.sync    = a_sync_ff;
      b_in.start   = a_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_bits_ff  <= req_tdata;
         a_sync_ff  <= req_tuser[0];
         a_start_ff <= req_tuser[1];
      end
      if (b_load) begin
         b_ff <= b_in;
      end
   end

   assign val_valid = b_valid_ff;
   assign val_item  = b_ff;

endmodule

// ===== rtl/gqhm_writer.sv =====
// Subcarrier write sequencer: head/tail bin pointers and the result register.
// Depends on gqhm_pkg.
module gqhm_writer #(
   parameter int FFT_SIZE = gqhm_pkg::FFT_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              val_valid,
   input  gqhm_pkg::value_type               val_item,
   output logic                              val_done,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gqhm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import gqhm_pkg::*;

   localparam int PTR_W = $clog2(FFT_SIZE);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FFT_SIZE - 1);
   localparam logic [PTR_W-1:0] PTR_FIRST = PTR_W'(1);

   typedef enum logic [3:0] {
      ST_FIRST  = 4'b0001,
      ST_SECOND = 4'b0010,
      ST_THIRD  = 4'b0100,
      ST_FOURTH = 4'b1000
   } step_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   step_type          state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [PTR_W-1:0]  head_cur, tail_cur, bin_ptr;
   logic [PTR_W+BIN_W-1:0] bin_ext;
   logic signed [VAL_W-1:0] re_sel, im_sel;
   logic              last_sel;
   logic              load;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]  rsp_bin_ff;
   logic signed [VAL_W-1:0] rsp_re_ff, rsp_im_ff;
   logic              rsp_last_ff;

   assign load = val_valid & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      head_cur = (val_item.start && state_ff == ST_FIRST) ? PTR_FIRST : head_ff;
      tail_cur = (val_item.start && state_ff == ST_FIRST) ? PTR_LAST  : tail_ff;
      head_in  = head_cur;
      tail_in  = tail_cur;
      bin_ptr  = head_cur;
      re_sel   = '0;
      im_sel   = '0;
      last_sel = 1'b0;
      state_in = ST_FIRST;
      unique case (state_ff)
         ST_FIRST: begin
            re_sel   = val_item.re;
            im_sel   = -val_item.im_prod;
            head_in  = ptr_inc(head_cur);
            state_in = ST_SECOND;
         end
         ST_SECOND: begin
            if (val_item.sync) begin
               head_in  = ptr_inc(head_ff);
               state_in = ST_THIRD;
            end else begin
               bin_ptr  = tail_ff;
               re_sel   = val_item.re;
               im_sel   = val_item.im_prod;
               last_sel = 1'b1;
               tail_in  = ptr_dec(tail_ff);
            end
         end
         ST_THIRD: begin
            bin_ptr  = tail_ff;
            re_sel   = val_item.re;
            im_sel   = val_item.im_prod;
            tail_in  = ptr_dec(tail_ff);
            state_in = ST_FOURTH;
         end
         ST_FOURTH: begin
            bin_ptr  = tail_ff;
            last_sel = 1'b1;
            tail_in  = ptr_dec(tail_ff);
         end
         default: state_in = ST_FIRST;
      endcase
      bin_ext = (PTR_W+BIN_W)'(bin_ptr);
   end

   assign val_done     = load & last_sel;
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FIRST;
         head_ff      <= PTR_FIRST;
         tail_ff      <= PTR_LAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            state_ff <= state_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_bin_ff  <= bin_ext[BIN_W-1:0];
         rsp_re_ff   <= re_sel;
         rsp_im_ff   <= im_sel;
         rsp_last_ff <= last_sel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_im_ff, rsp_re_ff, rsp_bin_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_sync_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_THIRD || state_ff == ST_FOURTH) |-> (val_valid && val_item.sync))
      else $error("third or fourth write without a held sync item");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (load && last_sel) |=> (state_ff == ST_FIRST))
      else $error("sequencer did not return to first write after last");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= PTR_LAST) && (tail_ff <= PTR_LAST))
      else $error("bin pointer beyond FFT size");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      val_done |-> (state_ff == ST_FOURTH || (state_ff == ST_SECOND && !val_item.sync)))
      else $error("item released on a non-final write");
`endif

endmodule

// ===== rtl/gray_qam_hermitian_mapper_unit.sv =====
// Top level of the Gray-coded QAM mapper with Hermitian subcarrier writes.
// Depends on gqhm_pkg, gqhm_csr, gqhm_level and gqhm_writer.
//
//   port group  direction  tdata / tuser                          tlast
//   req_        in         symbol_bits[7:0] / sync_mode, start    -
//   rsp_        out        bin[5:0], real[26:6], imag[47:27]      last_write
//   csr_        in         APB, data_gain @0x0, sync_gain @0x4    -
//
// One result leaves per cycle from the result register while rsp_tready is high;
// a data item gives two results, a sync item four, set by the write sequencer.
// Each item passes through the input and value registers before its first result is registered.
// Synchronous reset restores the gains, head bin 1 and tail bin FFT_SIZE-1.
// While a result waits on rsp_tready the input and value registers fill, then
// req_tready drops until the result moves on.
module gray_qam_hermitian_mapper_unit #(
   parameter int BITS_PER_SYMBOL = gqhm_pkg::BITS_PER_SYMBOL_DEF,
   parameter int FFT_SIZE        = gqhm_pkg::FFT_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gqhm_pkg::SYM_W-1:0]        req_tdata,  // symbol_bits
   input  logic [gqhm_pkg::REQ_USER_W-1:0]   req_tuser,  // sync_mode, start_symbol
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gqhm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // bin_index, real_part, imag_part
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gqhm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gqhm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gqhm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import gqhm_pkg::*;

   logic [GAIN_W-1:0] data_gain, sync_gain;
   logic              val_valid, val_done;
   value_type         val_item;

   gqhm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .data_gain   (data_gain),
      .sync_gain   (sync_gain)
   );

   gqhm_level #(
      .BITS_PER_SYMBOL (BITS_PER_SYMBOL)
   ) u_level (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .data_gain  (data_gain),
      .sync_gain  (sync_gain),
      .val_valid  (val_valid),
      .val_item   (val_item),
      .val_done   (val_done)
   );

   gqhm_writer #(
      .FFT_SIZE (FFT_SIZE)
   ) u_writer (
      .clock      (clock),
      .reset      (reset),
      .val_valid  (val_valid),
      .val_item   (val_item),
      .val_done   (val_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/gray_qam_hermitian_mapper_unit_test.sv =====
// Self-checking testbench for gray_qam_hermitian_mapper_unit: QAM symbols in, subcarrier
// writes out, gains set over the APB port. Needs gqhm_pkg and the mapper RTL only.
`timescale 1ns / 100ps

module gray_qam_hermitian_mapper_unit_test;
   import gqhm_pkg::*;

   localparam int SYM_BITS    = BITS_PER_SYMBOL_DEF;
   localparam int HALF_BITS   = SYM_BITS / 2;
   localparam int LEVEL_OFS   = (1 << HALF_BITS) - 1;
   localparam int N_BINS      = FFT_SIZE_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 40;
   localparam int N_ROWS      = 20;

   localparam logic [GRAY_W-1:0] GRAY_CODE [16] = '{
      4'd0, 4'd1, 4'd3, 4'd2, 4'd6, 4'd7, 4'd5, 4'd4,
      4'd12, 4'd13, 4'd15, 4'd14, 4'd10, 4'd11, 4'd9, 4'd8
   };

   typedef struct {
      logic [BIN_W-1:0]        bin;
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
      logic                    last;
   } bin_write_type;

   // pinned rows carry the head/tail writes of a data symbol typed in by hand
   typedef struct packed {
      logic [SYM_W-1:0]        bits;
      logic                    sync;
      logic                    start;
      logic                    pinned;
      logic [BIN_W-1:0]        head;
      logic [BIN_W-1:0]        tail;
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
   } symbol_row_type;

   localparam symbol_row_type SYMBOL_ROWS [N_ROWS] = '{
      '{8'h00, 1'b0, 1'b0, 1'b1, 6'd1, 6'd63, -21'sd24576,  21'sd24576},
      '{8'h0A, 1'b0, 1'b0, 1'b1, 6'd2, 6'd62,  21'sd24576, -21'sd24576},
      '{8'hF5, 1'b0, 1'b1, 1'b1, 6'd1, 6'd63, -21'sd8192,   21'sd8192},
      '{8'h00, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h0A, 1'b1, 1'b1, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'hAA, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h0F, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'hF0, 1'b0, 1'b1, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h33, 1'b1, 1'b1, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'hCC, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h81, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h7E, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h5A, 1'b0, 1'b1, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'hA5, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h96, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h69, 1'b1, 1'b1, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'h3C, 1'b0, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0},
      '{8'hC3, 1'b1, 1'b0, 1'b0, 6'd0, 6'd0,   21'sd0,      21'sd0}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [SYM_W-1:0]      req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;   // sync_mode, start_symbol
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // bin_index, real_part, imag_part
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bin_write_type    pending_writes[$];
   bin_write_type    symbol_writes [4];
   logic [GAIN_W-1:0] gain_data = DATA_GAIN_RST;
   logic [GAIN_W-1:0] gain_sync = SYNC_GAIN_RST;
   int               head_bin  = 1 % N_BINS;
   int               tail_bin  = N_BINS - 1;

   int error_count   = 0;
   int cycle_count   = 0;
   int symbol_count  = 0;
   int sync_count    = 0;
   int restart_count = 0;
   int write_count   = 0;
   int gain_writes   = 0;
   int rx_hold       = 0;
   bit tx_gaps       = 1'b1;
   bit rx_gaps       = 1'b1;

   gray_qam_hermitian_mapper_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d writes outstanding",
                  cycle_count, pending_writes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Gray level of one half of the symbol, times gain
   function automatic int scaled_level(input int idx, input int gain);
      return (2 * int'(GRAY_CODE[idx]) - LEVEL_OFS) * gain;
   endfunction

   // Fills symbol_writes with the subcarrier writes of one symbol, returns their count
   function automatic int map_symbol(input logic [SYM_W-1:0] bits, input logic sync,
                                     input logic start);
      int                      gain;
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
      if (start) begin
         head_bin = 1 % N_BINS;
         tail_bin = N_BINS - 1;
      end
      gain = sync ? int'(gain_sync) : int'(gain_data);
      re   = VAL_W'(scaled_level((bits >> (SYM_BITS - HALF_BITS)) & LEVEL_OFS, gain));
      im   = VAL_W'(-scaled_level(bits & LEVEL_OFS, gain));
      symbol_writes[0] = '{BIN_W'(head_bin), re, im, 1'b0};
      head_bin = (head_bin + 1) % N_BINS;
      if (!sync) begin
         symbol_writes[1] = '{BIN_W'(tail_bin), re, -im, 1'b1};
         tail_bin = (tail_bin + N_BINS - 1) % N_BINS;
         return 2;
      end
      symbol_writes[1] = '{BIN_W'(head_bin), '0, '0, 1'b0};
      head_bin = (head_bin + 1) % N_BINS;
      symbol_writes[2] = '{BIN_W'(tail_bin), re, -im, 1'b0};
      tail_bin = (tail_bin + N_BINS - 1) % N_BINS;
      symbol_writes[3] = '{BIN_W'(tail_bin), '0, '0, 1'b1};
      tail_bin = (tail_bin + N_BINS - 1) % N_BINS;
      return 4;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result sink: random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_gaps)
            rx_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      bin_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("unexpected write to bin %0d", rsp_tdata[BIN_W-1:0]);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            write_count++;
            if (rsp_tdata[BIN_W-1:0] !== want.bin) begin
               $error("bin_index: expected %0d, got %0d", want.bin, rsp_tdata[BIN_W-1:0]);
               error_count++;
            end
            if ($signed(rsp_tdata[BIN_W +: VAL_W]) !== want.re) begin
               $error("real_part: expected %0d, got %0d", want.re,
                      $signed(rsp_tdata[BIN_W +: VAL_W]));
               error_count++;
            end
            if ($signed(rsp_tdata[BIN_W+VAL_W +: VAL_W]) !== want.im) begin
               $error("imag_part: expected %0d, got %0d", want.im,
                      $signed(rsp_tdata[BIN_W+VAL_W +: VAL_W]));
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_write: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   task automatic send_symbol(input symbol_row_type row);
      int gap;
      int n;
      gap = tx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.bits;
      req_tuser  <= {row.start, row.sync};
      do @(posedge clock); while (!req_tready);
      n = map_symbol(row.bits, row.sync, row.start);
      if (row.pinned && !row.sync) begin
         pending_writes.push_back('{row.head, row.re, row.im, 1'b0});
         pending_writes.push_back('{row.tail, row.re, -row.im, 1'b1});
      end else begin
         for (int k = 0; k < n; k++)
            pending_writes.push_back(symbol_writes[k]);
      end
      symbol_count++;
      sync_count    += row.sync;
      restart_count += row.start;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic write_gain(input reg_index_type idx, input logic [GAIN_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom()), value};   // upper bits are don't-care
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_DATA_GAIN: gain_data = value;
         REG_SYNC_GAIN: gain_sync = value;
      endcase
      gain_writes++;
   endtask

   task automatic check_gain(input reg_index_type idx, input logic [GAIN_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[GAIN_W-1:0] !== want) begin
         $error("%s: expected %0d, got %0d", idx.name(), want, csr_prdata[GAIN_W-1:0]);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      symbol_row_type row;
      int             start_pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_gain(REG_DATA_GAIN, DATA_GAIN_RST);
      check_gain(REG_SYNC_GAIN, SYNC_GAIN_RST);

      for (int r = 0; r < N_ROWS; r++)
         send_symbol(SYMBOL_ROWS[r]);
      drain();

      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0: begin
               write_gain(REG_DATA_GAIN, 16'hFFFF);
               write_gain(REG_SYNC_GAIN, 16'h0000);
            end
            1: begin
               write_gain(REG_DATA_GAIN, 16'h0000);
               write_gain(REG_SYNC_GAIN, 16'hFFFF);
            end
            2: begin
               write_gain(REG_DATA_GAIN, 16'hFFFF);
               write_gain(REG_SYNC_GAIN, 16'hFFFF);
            end
            default: begin
               write_gain(REG_DATA_GAIN, 16'($urandom()));
               write_gain(REG_SYNC_GAIN, 16'($urandom()));
            end
         endcase
         check_gain(REG_DATA_GAIN, gain_data);
         check_gain(REG_SYNC_GAIN, gain_sync);
         tx_gaps   = (phase % 4) != 1;
         rx_gaps   = (phase % 4) != 2;
         // no restarts in some phases so the bin pointers wrap
         start_pct = (phase % 3 == 0) ? 0 : 12;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            row        = '0;
            row.bits   = SYM_W'($urandom_range(0, 255));
            row.sync   = $urandom_range(0, 99) < 35;
            row.start  = $urandom_range(0, 99) < start_pct;
            send_symbol(row);
         end
         drain();
      end

      rx_gaps = 1'b0;
      repeat (16) @(posedge clock);
      $display("%0d symbols sent (%0d sync, %0d restarts), %0d subcarrier writes checked",
               symbol_count, sync_count, restart_count, write_count);
      $display("%0d gain register writes, gains including both extremes", gain_writes);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
